### rtl/osm_pkg.sv
// Shared types and constants for the order-statistic multiset.
package osm_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int DW = 32;

    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_DELETE = 3'd1,
        K_RANK   = 3'd2,
        K_SELECT = 3'd3,
        K_PRED   = 3'd4,
        K_SUCC   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic                 cmp;
        logic                 ins;
        logic                 del;
        logic signed [DW-1:0] v;
    } ctl_t;

endpackage

### rtl/osm_cell.sv
// One storage cell of the sorted chain: value, valid bit and compare flags.
module osm_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  osm_pkg::ctl_t                ctl,
    input  logic signed [osm_pkg::DW-1:0] left_val,
    input  logic                         left_valid,
    input  logic                         left_le,
    input  logic signed [osm_pkg::DW-1:0] right_val,
    input  logic                         right_valid,
    output logic signed [osm_pkg::DW-1:0] val,
    output logic                         valid,
    output logic                         lt,
    output logic                         le
);

    logic signed [osm_pkg::DW-1:0] val_reg, val_next;
    logic valid_reg, valid_next, lt_reg, lt_next, le_reg, le_next;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        le_next    = le_reg;
        if (ctl.cmp)
        begin
            lt_next = valid_reg && (val_reg < ctl.v);
            le_next = valid_reg && (val_reg <= ctl.v);
        end
        else if (ctl.ins && !le_reg)
        begin
            if (left_le)
            begin
                val_next   = ctl.v;
                valid_next = 1'b1;
            end
            else
            begin
                val_next   = left_val;
                valid_next = left_valid;
            end
        end
        else if (ctl.del && !lt_reg)
        begin
            val_next   = right_val;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            le_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            le_reg    <= le_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign le    = le_reg;

endmodule

### rtl/osm_reduce.sv
// Boundary detection and one-hot readout over the cell flags.
module osm_reduce #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic [CAPACITY-1:0]                         lt,
    input  logic [CAPACITY-1:0]                         le,
    input  logic [CAPACITY-1:0]                         valid,
    input  logic [CAPACITY-1:0][osm_pkg::DW-1:0]        vals,
    input  logic [osm_pkg::DW-1:0]                      k,
    output logic [CW-1:0]                               cnt_lt,
    output logic [CW-1:0]                               cnt_le,
    output logic [osm_pkg::DW-1:0]                      pred,
    output logic [osm_pkg::DW-1:0]                      succ,
    output logic [osm_pkg::DW-1:0]                      sel
);

    logic [CAPACITY-1:0] b_lt, b_le, h_succ, h_sel;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            b_lt[i]   = lt[i] && ((i == CAPACITY - 1) || !lt[(i + 1) % CAPACITY]);
            b_le[i]   = le[i] && ((i == CAPACITY - 1) || !le[(i + 1) % CAPACITY]);
            h_succ[i] = valid[i] && !le[i] && ((i == 0) || le[(i + CAPACITY - 1) % CAPACITY]);
            h_sel[i]  = valid[i] && (k == 32'(i + 1));
        end
    end

    always_comb
    begin
        cnt_lt = '0;
        cnt_le = '0;
        pred   = '0;
        succ   = '0;
        sel    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cnt_lt = cnt_lt | ({CW{b_lt[i]}} & CW'(i + 1));
            cnt_le = cnt_le | ({CW{b_le[i]}} & CW'(i + 1));
            pred   = pred | ({osm_pkg::DW{b_lt[i]}} & vals[i]);
            succ   = succ | ({osm_pkg::DW{h_succ[i]}} & vals[i]);
            sel    = sel | ({osm_pkg::DW{h_sel[i]}} & vals[i]);
        end
    end

endmodule

### rtl/order_statistic_multiset.sv
// Top level: sequencer, element count and result register around the cell chain.
// An accepted input passes the compare state, then the execute state, which registers the result.
// Only one item is in flight at a time; a result that waits holds off the next input.
// Reset: all cells empty, count zero, no result pending; values need no clearing.
module order_statistic_multiset #(
    parameter int CAPACITY = osm_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          kind,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  answer,
    output logic [1:0]          status
);

    localparam int CW = $clog2(CAPACITY + 1);

    osm_pkg::state_t state_reg, state_next;
    logic [2:0]         kind_reg;
    logic signed [31:0] v_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg;
    logic signed [31:0] answer_reg, answer_next;
    logic [1:0]         status_reg, status_next;

    osm_pkg::ctl_t ctl;
    logic [CAPACITY-1:0] lt, le, vld;
    logic [CAPACITY-1:0][31:0] vals;
    logic [CW-1:0] cnt_lt, cnt_le;
    logic [31:0] pred, succ, sel;
    logic full, found;

    assign full  = (count_reg == CW'(CAPACITY));
    assign found = (cnt_lt != cnt_le);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            osm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .left_val   ((g == 0) ? 32'sd0 : $signed(vals[(g + CAPACITY - 1) % CAPACITY])),
                .left_valid ((g == 0) ? 1'b1 : vld[(g + CAPACITY - 1) % CAPACITY]),
                .left_le    ((g == 0) ? 1'b1 : le[(g + CAPACITY - 1) % CAPACITY]),
                .right_val  ((g == CAPACITY - 1) ? 32'sd0 : $signed(vals[(g + 1) % CAPACITY])),
                .right_valid((g == CAPACITY - 1) ? 1'b0 : vld[(g + 1) % CAPACITY]),
                .val        (vals[g]),
                .valid      (vld[g]),
                .lt         (lt[g]),
                .le         (le[g])
            );
        end
    endgenerate

    osm_reduce #(.CAPACITY(CAPACITY), .CW(CW)) u_reduce (
        .lt    (lt),
        .le    (le),
        .valid (vld),
        .vals  (vals),
        .k     (v_reg),
        .cnt_lt(cnt_lt),
        .cnt_le(cnt_le),
        .pred  (pred),
        .succ  (succ),
        .sel   (sel)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            osm_pkg::S_IDLE:
                if (in_valid && in_ready)
                    state_next = osm_pkg::S_CMP;
            osm_pkg::S_CMP:
                state_next = osm_pkg::S_EXEC;
            osm_pkg::S_EXEC:
                state_next = osm_pkg::S_IDLE;
            default:
                state_next = osm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.cmp = (state_reg == osm_pkg::S_CMP);
        ctl.ins = (state_reg == osm_pkg::S_EXEC) && (kind_reg == osm_pkg::K_INSERT) && !full;
        ctl.del = (state_reg == osm_pkg::S_EXEC) && (kind_reg == osm_pkg::K_DELETE) && found;
        ctl.v   = v_reg;
        in_ready = (state_reg == osm_pkg::S_IDLE) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        answer_next = '0;
        status_next = osm_pkg::ST_OK;
        count_next  = count_reg;
        case (kind_reg)
            osm_pkg::K_INSERT:
                if (full)
                    status_next = osm_pkg::ST_FULL;
                else
                    count_next = count_reg + CW'(1);
            osm_pkg::K_DELETE:
                if (found)
                    count_next = count_reg - CW'(1);
                else
                    status_next = osm_pkg::ST_NONE;
            osm_pkg::K_RANK:
                answer_next = $signed(32'(cnt_lt) + 32'd1);
            osm_pkg::K_SELECT:
                if (v_reg < 32'sd1 || $unsigned(v_reg) > 32'(count_reg))
                    status_next = osm_pkg::ST_RANGE;
                else
                    answer_next = $signed(sel);
            osm_pkg::K_PRED:
                if (cnt_lt == '0)
                    status_next = osm_pkg::ST_NONE;
                else
                    answer_next = $signed(pred);
            osm_pkg::K_SUCC:
                if (cnt_le == count_reg)
                    status_next = osm_pkg::ST_NONE;
                else
                    answer_next = $signed(succ);
            default:
                answer_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= osm_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == osm_pkg::S_EXEC)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= kind;
            v_reg    <= value;
        end
        if (state_reg == osm_pkg::S_EXEC)
        begin
            answer_reg <= answer_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == osm_pkg::S_CMP |=> state_reg == osm_pkg::S_EXEC)
        else $error("compare not followed by execute");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == osm_pkg::S_EXEC))
        else $error("result without execute");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != osm_pkg::S_EXEC |=> $stable(count_reg))
        else $error("count changed outside execute");

endmodule
